@@ design/usl_pkg.sv @@
`timescale 1ns / 1ps

package usl_pkg;

    localparam int NEEDLE_MAX_DEF = 64;
    localparam int COUNT_BITS_DEF = 48;

    localparam int OP_W       = 2;
    localparam int DATA_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int OFFSET_W   = 48;
    localparam int OUT_LEN_W  = 49;
    localparam int REPL_W     = 40;
    localparam int HIT_W      = 2;

    localparam logic [HIT_W-1:0] HIT_CAP = HIT_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_NEEDLE = 2'd1,
        OP_SOURCE = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT    = 3'd0,
        ST_UNIQUE    = 3'd1,
        ST_AMBIGUOUS = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD       = 3'd4
    } t_status;

    typedef struct packed {
        logic              push_needle;
        logic              push_window;
        logic [DATA_W-1:0] data;
    } t_match_ctl;

endpackage

@@ design/usl_window_match.sv @@
`timescale 1ns / 1ps

module usl_window_match #(
    parameter int NEEDLE_MAX = usl_pkg::NEEDLE_MAX_DEF
) (
    input  logic                              i_clk,
    input  usl_pkg::t_match_ctl               i_ctl,
    input  logic [$clog2(NEEDLE_MAX+1)-1:0]   i_count,
    output logic                              o_match
);
    import usl_pkg::*;

    localparam int NC_W = $clog2(NEEDLE_MAX + 1);

    // needle held newest-first, aligned with the window
    logic [DATA_W-1:0] r_needle [NEEDLE_MAX];
    logic [DATA_W-1:0] r_window [NEEDLE_MAX];
    logic [DATA_W-1:0] w_win_next [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] w_lane_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_needle) begin
            r_needle[0] <= i_ctl.data;
            for (int j = 1; j < NEEDLE_MAX; j++) begin
                r_needle[j] <= r_needle[j-1];
            end
        end
        if (i_ctl.push_window) begin
            for (int j = 0; j < NEEDLE_MAX; j++) begin
                r_window[j] <= w_win_next[j];
            end
        end
    end

    always_comb begin
        w_win_next[0] = i_ctl.data;
        for (int j = 1; j < NEEDLE_MAX; j++) begin
            w_win_next[j] = r_window[j-1];
        end
    end

    for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_lane
        assign w_lane_ok[g] = (NC_W'(g) >= i_count) || (r_needle[g] == w_win_next[g]);
    end

    assign o_match = &w_lane_ok;

endmodule

@@ design/unique_substring_locator_unit.sv @@
`timescale 1ns / 1ps
// An input word is held in the input stage, then its result in the result stage.
// Throughput: 1 word per cycle unless the output stalls; the whole needle is
// compared against the window in parallel in the single stage between the input
// and result registers. Reset (synchronous, active low) empties the needle,
// restarts the search, zeroes the replacement length, drops both pipeline valids.
module unique_substring_locator_unit #(
    parameter int NEEDLE_MAX = usl_pkg::NEEDLE_MAX_DEF,
    parameter int COUNT_BITS = usl_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [usl_pkg::OP_W-1:0]        i_op,
    input  logic [usl_pkg::DATA_W-1:0]      i_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [usl_pkg::STATUS_W-1:0]    o_status,
    output logic [usl_pkg::OFFSET_W-1:0]    o_match_offset,
    output logic [usl_pkg::OUT_LEN_W-1:0]   o_output_length,
    input  logic                            i_cfg_we,
    input  logic [usl_pkg::REPL_W-1:0]      i_cfg_data
);
    import usl_pkg::*;

    localparam int NC_W  = $clog2(NEEDLE_MAX + 1);
    localparam int POS_W = COUNT_BITS + 1;
    localparam int LEN_W = ((COUNT_BITS > OUT_LEN_W) ? COUNT_BITS : OUT_LEN_W) + 1;

    // input stage
    logic              r_in_vld;
    t_op               r_op;
    logic [DATA_W-1:0] r_data;

    // search state
    logic [NC_W-1:0]       r_ncount, n_ncount;
    logic                  r_novf, n_novf;
    logic [COUNT_BITS-1:0] r_seen, n_seen;
    logic [HIT_W-1:0]      r_hit, n_hit;
    logic [COUNT_BITS-1:0] r_first, n_first;
    logic                  r_closed, n_closed;
    logic [REPL_W-1:0]     r_repl;

    // result stage
    logic                 r_out_vld;
    t_status              r_status, n_status;
    logic [OFFSET_W-1:0]  r_off, n_off;
    logic [OUT_LEN_W-1:0] r_len, n_len;

    logic       w_adv;
    logic       w_fire;
    logic       w_match;
    logic       w_push_needle;
    logic       w_push_window;
    t_match_ctl w_ctl;

    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;

    assign w_ctl.push_needle = w_fire && w_push_needle;
    assign w_ctl.push_window = w_fire && w_push_window;
    assign w_ctl.data        = r_data;

    usl_window_match #(
        .NEEDLE_MAX(NEEDLE_MAX)
    ) u_match (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_count(r_ncount),
        .o_match(w_match)
    );

    always_comb begin
        logic            bad;
        logic [POS_W-1:0] pos1;
        logic [POS_W-1:0] ncount_ext;
        logic [LEN_W-1:0] len_wide;
        logic [LEN_W-1:0] off_wide;

        bad        = (r_ncount == '0) || r_novf;
        pos1       = POS_W'(r_seen) + POS_W'(1);
        ncount_ext = POS_W'(r_ncount);
        off_wide   = LEN_W'(r_first);
        len_wide   = LEN_W'(r_seen) - LEN_W'(r_ncount) + LEN_W'(r_repl);

        n_ncount      = r_ncount;
        n_novf        = r_novf;
        n_seen        = r_seen;
        n_hit         = r_hit;
        n_first       = r_first;
        n_closed      = r_closed;
        n_status      = ST_ACCEPT;
        n_off         = '0;
        n_len         = '0;
        w_push_needle = 1'b0;
        w_push_window = 1'b0;

        case (r_op)
            OP_CLEAR: begin
                n_ncount = '0;
                n_novf   = 1'b0;
                n_seen   = '0;
                n_hit    = '0;
                n_first  = '0;
                n_closed = 1'b0;
            end
            OP_NEEDLE: begin
                if (r_seen == '0 && !r_closed) begin
                    if (r_ncount < NC_W'(NEEDLE_MAX)) begin
                        w_push_needle = 1'b1;
                        n_ncount      = r_ncount + NC_W'(1);
                    end else begin
                        n_novf = 1'b1;
                    end
                end
            end
            OP_SOURCE: begin
                if (bad) begin
                    n_status = ST_BAD;
                end else if (r_closed) begin
                    n_status = (r_hit >= HIT_CAP) ? ST_AMBIGUOUS : ST_ACCEPT;
                end else begin
                    w_push_window = 1'b1;
                    if (!(&r_seen)) begin
                        n_seen = r_seen + COUNT_BITS'(1);
                    end
                    if (pos1 >= ncount_ext && w_match) begin
                        if (r_hit == '0) begin
                            n_hit   = HIT_W'(1);
                            n_first = COUNT_BITS'(pos1 - ncount_ext);
                        end else begin
                            n_hit    = HIT_CAP;
                            n_closed = 1'b1;
                            n_status = ST_AMBIGUOUS;
                        end
                    end
                end
            end
            OP_END: begin
                if (bad) begin
                    n_status = ST_BAD;
                end else begin
                    n_closed = 1'b1;
                    if (r_hit == '0) begin
                        n_status = ST_NOT_FOUND;
                    end else if (r_hit >= HIT_CAP) begin
                        n_status = ST_AMBIGUOUS;
                    end else begin
                        n_status = ST_UNIQUE;
                        n_off    = off_wide[OFFSET_W-1:0];
                        n_len    = len_wide[OUT_LEN_W-1:0];
                    end
                end
            end
            default: begin
                n_status = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ncount  <= '0;
            r_novf    <= 1'b0;
            r_seen    <= '0;
            r_hit     <= '0;
            r_first   <= '0;
            r_closed  <= 1'b0;
            r_repl    <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
                r_ncount  <= n_ncount;
                r_novf    <= n_novf;
                r_seen    <= n_seen;
                r_hit     <= n_hit;
                r_first   <= n_first;
                r_closed  <= n_closed;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_repl <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op   <= t_op'(i_op);
            r_data <= i_data;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_off    <= n_off;
            r_len    <= n_len;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_match_offset  = r_off;
    assign o_output_length = r_len;

    a_hit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit <= HIT_CAP)
        else $error("hit count beyond cap");

    a_cap_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit == HIT_CAP) |-> r_closed)
        else $error("second hit left search open");

    a_needle_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncount <= NC_W'(NEEDLE_MAX))
        else $error("needle count beyond capacity");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked result");

    a_source_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen != '0) |-> (r_ncount != '0 && !r_novf))
        else $error("source counted with bad needle");

endmodule
